>>> rtl/core/log_linear_table_interpolator_core_assert.svh
// Assertion macros for the interpolator core.
`ifndef LOG_LINEAR_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define LOG_LINEAR_TABLE_INTERPOLATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define LLTI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("llti assertion failed");
`define LLTI_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("llti assertion failed");
`else
`define LLTI_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LLTI_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/llti_pkg.sv
`default_nettype none

package llti_pkg;

  localparam int LLTI_TABLE_DEPTH = 256;

  localparam int POS_W = 20;
  localparam int VAL_W = 32;
  localparam int CFG_W = 9;
  localparam int IDX_W = 8;
  localparam int ST_W  = 2;
  localparam int FRAC_W = 24;
  localparam int LOG_W = 29;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } entry_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_m;
    v = v_in;
    res = 64'd0;
    bit_m = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bit_m) begin
        v = v - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res = res >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return res;
  endfunction

  function automatic logic [FRAC_W*32-1:0] make_roots();
    logic [FRAC_W*32-1:0] tbl;
    logic [63:0] root;
    tbl = '0;
    root = 64'h0000_0000_8000_0000;
    for (int j = 0; j < FRAC_W; j++) begin
      root = isqrt64(root << 30);
      tbl[j*32 +: 32] = root[31:0];
    end
    return tbl;
  endfunction

  localparam logic [FRAC_W*32-1:0] ROOTS = make_roots();

endpackage

`default_nettype wire

>>> rtl/core/log_linear_table_interpolator_core.sv
// Log-linear table interpolator.
// Input channel (in_valid_i / in_stall_o): an item transfers on a rising edge
// with valid high and stall low. A write item (operation 0) stores one table
// entry in the transfer cycle and gives no result; the block is ready again
// in the next cycle. A query item (operation 1) gives one result.
// Output channel (out_valid_o / out_stall_i): one registered result per query;
// it holds while the receiver stalls. A finished query waits in its final
// state with the input stalled until the output register is free.
// A query on an empty table goes straight to its final state. A query reads
// the first and last table entries and is clamped if it lies outside them.
// An interpolated query then scans the entries up to the bracketing entry,
// takes 16 divide steps, forms two logarithms by normalizing and squaring,
// computes the exponent product and the exponent steps, and rounds and
// shifts. The next item can transfer in the cycle after the result moves to
// the output register. All products go through one shared 32x32 multiplier
// with a registered output.
// Configuration: cfg_wr_en_i writes entries_used at once; write it only idle.
// Reset clears the control state and entries_used; table contents are
// undefined until written.
`default_nettype none

`include "log_linear_table_interpolator_core_assert.svh"

module log_linear_table_interpolator_core #(
  parameter int TABLE_DEPTH = llti_pkg::LLTI_TABLE_DEPTH
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_wr_en_i,
  input  wire [llti_pkg::CFG_W-1:0]   cfg_wr_data_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         in_operation_i,
  input  wire [llti_pkg::IDX_W-1:0]   in_entry_index_i,
  input  wire [llti_pkg::POS_W-1:0]   in_entry_x_i,
  input  wire [llti_pkg::VAL_W-1:0]   in_entry_y_i,
  input  wire [llti_pkg::POS_W-1:0]   in_query_x_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [llti_pkg::VAL_W-1:0]  out_value_o,
  output logic [llti_pkg::ST_W-1:0]   out_status_o
);
  import llti_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD0   = 5'd1;
  localparam logic [4:0] S_RDL   = 5'd2;
  localparam logic [4:0] S_CLAMP = 5'd3;
  localparam logic [4:0] S_SCAN  = 5'd4;
  localparam logic [4:0] S_DIV   = 5'd5;
  localparam logic [4:0] S_NORM  = 5'd6;
  localparam logic [4:0] S_SQ    = 5'd7;
  localparam logic [4:0] S_SQW   = 5'd8;
  localparam logic [4:0] S_TMUL  = 5'd9;
  localparam logic [4:0] S_TMULW = 5'd10;
  localparam logic [4:0] S_EXP   = 5'd11;
  localparam logic [4:0] S_EXPW  = 5'd12;
  localparam logic [4:0] S_PMUL  = 5'd13;
  localparam logic [4:0] S_PMULW = 5'd14;
  localparam logic [4:0] S_RND   = 5'd15;
  localparam logic [4:0] S_SHIFT = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_q, state_d;
  logic [CFG_W-1:0] entries_q;
  logic [CW-1:0] n, nm1;
  logic [CW-1:0] ptr_q, ptr_d;
  logic have_q, have_d;

  logic [POS_W-1:0] qx_q, qx_d;
  logic [POS_W-1:0] x0_q, x0_d;
  logic [VAL_W-1:0] y0_q, y0_d, y1_q, y1_d;
  logic [POS_W-1:0] rem_q, rem_d, dsr_q, dsr_d;
  logic [15:0] t_q, t_d;
  logic [4:0] stp_q, stp_d;
  logic lsel_q, lsel_d;
  logic [31:0] m_q, m_d;
  logic [4:0] msb_q, msb_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [LOG_W-1:0] l0_q, l0_d, l1;
  logic [LOG_W-1:0] ad_q, ad_d;
  logic neg_q, neg_d;
  logic [FRAC_W-1:0] f_q, f_d;
  logic [5:0] sh_q, sh_d;
  logic [31:0] acc_q, acc_d;
  logic [64:0] rnd_q, rnd_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  logic [ST_W-1:0] res_st_q, res_st_d;

  logic out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_value_q, out_value_d;
  logic [ST_W-1:0] out_status_q, out_status_d;

  logic in_xfer;
  logic tbl_we;
  logic [AW-1:0] rd_addr;
  entry_t wdata, rdata;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [20:0] div_shl;
  logic [44:0] mag_sum;
  logic [LOG_W-1:0] mag, mag_neg;
  logic [5:0] kq;
  logic [64:0] shr;
  logic [31:0] root;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer = in_valid_i && !in_stall_o;
  assign tbl_we = in_xfer && (in_operation_i == OP_WRITE) &&
                  ({24'd0, in_entry_index_i} < TABLE_DEPTH);
  assign wdata.pos = in_entry_x_i;
  assign wdata.val = in_entry_y_i;

  assign n = ({23'd0, entries_q} > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(entries_q);
  assign nm1 = n - CW'(1);

  llti_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(in_entry_index_i)),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  llti_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign root = ROOTS[{stp_q, 5'd0} +: 32];
  assign div_shl = {rem_q, 1'b0};
  assign mag_sum = mul_p[44:0] + 45'h8000;
  assign mag = mag_sum[44:16];
  assign mag_neg = LOG_W'(0) - mag;
  assign kq = {1'b0, mag[28:24]} + {5'd0, (mag[23:0] != 24'd0)};
  assign shr = (sh_q == 6'd0) ? (rnd_q << 1) : (rnd_q >> (sh_q - 6'd1));

  always_comb begin
    frac_d = {frac_q[FRAC_W-2:0], mul_p[63]};
    l1 = {msb_q, frac_d};
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      S_SQ: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      S_TMUL: begin
        mul_a = {16'd0, t_q};
        mul_b = {3'd0, ad_q};
      end
      S_EXP: begin
        mul_a = acc_q;
        mul_b = root;
      end
      S_PMUL: begin
        mul_a = y0_q;
        mul_b = acc_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    have_d = have_q;
    qx_d = qx_q;
    x0_d = x0_q;
    y0_d = y0_q;
    y1_d = y1_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    t_d = t_q;
    stp_d = stp_q;
    lsel_d = lsel_q;
    m_d = m_q;
    msb_d = msb_q;
    l0_d = l0_q;
    ad_d = ad_q;
    neg_d = neg_q;
    f_d = f_q;
    sh_d = sh_q;
    acc_d = acc_q;
    rnd_d = rnd_q;
    res_val_d = res_val_q;
    res_st_d = res_st_q;
    rd_addr = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_operation_i == OP_QUERY)) begin
          qx_d = in_query_x_i;
          if (n == '0) begin
            res_val_d = '0;
            res_st_d = ST_EMPTY;
            state_d = S_DONE;
          end else begin
            state_d = S_RD0;
          end
        end
      end
      S_RD0: begin
        state_d = S_RDL;
      end
      S_RDL: begin
        rd_addr = nm1[AW-1:0];
        x0_d = rdata.pos;
        y0_d = rdata.val;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        res_st_d = ST_OK;
        if (qx_q < x0_q) begin
          res_val_d = y0_q;
          state_d = S_DONE;
        end else if (qx_q >= rdata.pos) begin
          res_val_d = rdata.val;
          state_d = S_DONE;
        end else begin
          ptr_d = CW'(1);
          have_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = ptr_q[AW-1:0];
        ptr_d = ptr_q + CW'(1);
        have_d = 1'b1;
        if (have_q) begin
          if (qx_q < rdata.pos) begin
            y1_d = rdata.val;
            dsr_d = rdata.pos - x0_q;
            rem_d = qx_q - x0_q;
            stp_d = '0;
            if ((y0_q == '0) || (rdata.val == '0)) begin
              res_val_d = '0;
              res_st_d = ST_ZERO;
              state_d = S_DONE;
            end else begin
              state_d = S_DIV;
            end
          end else begin
            x0_d = rdata.pos;
            y0_d = rdata.val;
          end
        end
      end
      S_DIV: begin
        if (div_shl >= {1'b0, dsr_q}) begin
          rem_d = POS_W'(div_shl - {1'b0, dsr_q});
          t_d = {t_q[14:0], 1'b1};
        end else begin
          rem_d = div_shl[POS_W-1:0];
          t_d = {t_q[14:0], 1'b0};
        end
        stp_d = stp_q + 5'd1;
        if (stp_q == 5'd15) begin
          lsel_d = 1'b0;
          m_d = y0_q;
          msb_d = 5'd31;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (m_q[31]) begin
          stp_d = '0;
          state_d = S_SQ;
        end else begin
          m_d = {m_q[30:0], 1'b0};
          msb_d = msb_q - 5'd1;
        end
      end
      S_SQ: begin
        state_d = S_SQW;
      end
      S_SQW: begin
        m_d = mul_p[63] ? mul_p[63:32] : mul_p[62:31];
        stp_d = stp_q + 5'd1;
        state_d = S_SQ;
        if (stp_q == 5'd23) begin
          if (!lsel_q) begin
            l0_d = l1;
            lsel_d = 1'b1;
            m_d = y1_q;
            msb_d = 5'd31;
            state_d = S_NORM;
          end else begin
            neg_d = l1 < l0_q;
            ad_d = (l1 < l0_q) ? (l0_q - l1) : (l1 - l0_q);
            state_d = S_TMUL;
          end
        end
      end
      S_TMUL: begin
        state_d = S_TMULW;
      end
      S_TMULW: begin
        if (!neg_q) begin
          f_d = mag[23:0];
          sh_d = 6'd31 - {1'b0, mag[28:24]};
        end else begin
          f_d = mag_neg[23:0];
          sh_d = 6'd31 + kq;
        end
        acc_d = 32'h4000_0000;
        stp_d = '0;
        state_d = S_EXP;
      end
      S_EXP: begin
        if (f_q[FRAC_W-1]) begin
          state_d = S_EXPW;
        end else begin
          f_d = {f_q[FRAC_W-2:0], 1'b0};
          stp_d = stp_q + 5'd1;
          if (stp_q == 5'd23) begin
            state_d = S_PMUL;
          end
        end
      end
      S_EXPW: begin
        acc_d = mul_p[61:30];
        f_d = {f_q[FRAC_W-2:0], 1'b0};
        stp_d = stp_q + 5'd1;
        state_d = (stp_q == 5'd23) ? S_PMUL : S_EXP;
      end
      S_PMUL: begin
        state_d = S_PMULW;
      end
      S_PMULW: begin
        rnd_d = {1'b0, mul_p};
        state_d = S_RND;
      end
      S_RND: begin
        if (sh_q >= 6'd2) begin
          rnd_d = rnd_q + (65'd1 << (sh_q - 6'd2));
        end
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        res_st_d = ST_OK;
        res_val_d = (shr[64:32] != '0) ? 32'hFFFF_FFFF : shr[31:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_status_d = out_status_q;
    if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      out_value_d = res_val_q;
      out_status_d = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      entries_q <= '0;
      out_valid_q <= 1'b0;
      ptr_q <= '0;
      have_q <= 1'b0;
      stp_q <= '0;
      lsel_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr_en_i) begin
        entries_q <= cfg_wr_data_i;
      end
      out_valid_q <= out_valid_d;
      ptr_q <= ptr_d;
      have_q <= have_d;
      stp_q <= stp_d;
      lsel_q <= lsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q <= qx_d;
    x0_q <= x0_d;
    y0_q <= y0_d;
    y1_q <= y1_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    t_q <= t_d;
    m_q <= m_d;
    msb_q <= msb_d;
    frac_q <= (state_q == S_SQW) ? frac_d : ((state_q == S_NORM) ? '0 : frac_q);
    l0_q <= l0_d;
    ad_q <= ad_d;
    neg_q <= neg_d;
    f_q <= f_d;
    sh_q <= sh_d;
    acc_q <= acc_d;
    rnd_q <= rnd_d;
    res_val_q <= res_val_d;
    res_st_q <= res_st_d;
    out_value_q <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_status_o = out_status_q;

  `LLTI_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && (out_status_o != ST_OK), out_value_o == '0)
  `LLTI_ASSERT_NXT(a_query_busy, clk_i, rst_ni, in_xfer && (in_operation_i == OP_QUERY), in_stall_o)
  `LLTI_ASSERT_IMP(a_scan_bound, clk_i, rst_ni, state_q == S_SCAN, ptr_q <= n)

endmodule

`default_nettype wire

>>> rtl/core/llti_table.sv
`default_nettype none

module llti_table #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire [AW-1:0]         waddr_i,
  input  llti_pkg::entry_t     wdata_i,
  input  wire [AW-1:0]         raddr_i,
  output llti_pkg::entry_t     rdata_o
);
  import llti_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/llti_mul.sv
`default_nettype none

module llti_mul (
  input  wire         clk_i,
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  output logic [63:0] p_o
);
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;

endmodule

`default_nettype wire
